@@ hw/rtl/cpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants for the convex polygon check
// Vertex and result payloads, queue entry layout, turn codes and sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

  // coordinate and arithmetic widths
  localparam int CoordW = 16;
  localparam int DiffW  = CoordW + 1;
  localparam int ProdW  = 2 * DiffW;
  localparam int SumW   = ProdW + 1;

  // polygon needs at least this many vertices
  localparam int VertexMin = 3;
  localparam int SeenW     = 2;

  // triples that one vertex can close: the regular one and two wrap-around ones
  localparam int NumTri = 3;
  localparam int TriReg = 0;
  localparam int TriWrapA = 1;
  localparam int TriWrapB = 2;

  // queue between front and back
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    TURN_ZERO = 2'd0,
    TURN_NEG  = 2'd1,
    TURN_POS  = 2'd2
  } turn_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic                     last_vertex;
  } vertex_in_t;

  typedef struct packed {
    logic is_convex;
    logic too_few;
  } result_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } point_t;

  // one queue entry: the new vertex plus the history it needs
  typedef struct packed {
    point_t           cur;
    point_t           older;
    point_t           newer;
    point_t           first;
    point_t           second;
    logic [SeenW-1:0] seen;
    logic             last;
  } job_t;

  // products registered between the multiply and the sign stage
  typedef struct packed {
    logic [NumTri-1:0][ProdW-1:0] pa;
    logic [NumTri-1:0][ProdW-1:0] pb;
    logic [NumTri-1:0]            tv;
    logic                         last;
    logic                         too_few;
  } prod_t;

endpackage

`default_nettype wire

@@ hw/rtl/cpc_front.sv @@
// ----------------------------------------------------------------------------
// cpc_front: vertex intake
// Accepts vertices, keeps the first two and the last two, and pushes one
// job per vertex with everything the back end needs to form its triples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpc_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  vertex_valid,
  output logic                 vertex_stall,
  input  cpc_pkg::vertex_in_t  vertex,
  input  wire                  q_full,
  output logic                 push,
  output cpc_pkg::job_t        push_job
);
  import cpc_pkg::*;

  point_t           first;
  point_t           second;
  point_t           older;
  point_t           newer;
  logic [SeenW-1:0] seen;
  logic [SeenW-1:0] seen_next;
  point_t           cur;

  assign cur.x        = vertex.vertex_x;
  assign cur.y        = vertex.vertex_y;
  assign vertex_stall = q_full;
  assign push         = vertex_valid && !q_full;

  // build the job from the current history and the new vertex
  always_comb begin
    push_job.cur    = cur;
    push_job.older  = older;
    push_job.newer  = newer;
    push_job.first  = first;
    push_job.second = second;
    push_job.seen   = seen;
    push_job.last   = vertex.last_vertex;
  end

  // count vertices, saturate, restart after the last one
  always_comb begin
    if (vertex.last_vertex) begin
      seen_next = '0;
    end else if (seen < SeenW'(VertexMin)) begin
      seen_next = seen + SeenW'(1);
    end else begin
      seen_next = seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (push) begin
      seen <= seen_next;
    end
  end

  // shift vertex history
  always_ff @(posedge clk) begin
    if (push) begin
      if (seen == SeenW'(0)) begin
        first <= cur;
      end
      if (seen == SeenW'(1)) begin
        second <= cur;
      end
      older <= newer;
      newer <= cur;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cpc_queue.sv @@
// ----------------------------------------------------------------------------
// cpc_queue: job queue
// Small register queue between intake and evaluation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpc_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  cpc_pkg::job_t  push_job,
  output logic           full,
  input  wire            pop,
  output logic           head_valid,
  output cpc_pkg::job_t  head_job
);
  import cpc_pkg::*;

  job_t             entries [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    if (p == QPtrW'(QDepth - 1)) begin
      return '0;
    end
    return p + QPtrW'(1);
  endfunction

  assign full       = (count == QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCntW'(1);
      end else if (pop && !push) begin
        count <= count - QCntW'(1);
      end
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cpc_back.sv @@
// ----------------------------------------------------------------------------
// cpc_back: turn evaluation
// Multiplies edge vectors of up to three triples, then takes the sign of
// each cross product, folds it into the running turn state and emits the
// verdict on the last vertex.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpc_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              head_valid,
  input  cpc_pkg::job_t    head_job,
  output logic             pop,
  output logic             result_valid,
  input  wire              result_stall,
  output cpc_pkg::result_t result
);
  import cpc_pkg::*;

  point_t                  ta [NumTri];
  point_t                  tb [NumTri];
  point_t                  tc [NumTri];
  logic signed [DiffW-1:0] dx1 [NumTri];
  logic signed [DiffW-1:0] dy1 [NumTri];
  logic signed [DiffW-1:0] dx2 [NumTri];
  logic signed [DiffW-1:0] dy2 [NumTri];
  prod_t                   prod_next;
  prod_t                   prod;
  logic                    prod_valid;
  logic                    drain;
  logic                    closes;
  turn_t                   turn_sign;
  logic                    sign_conflict;
  turn_t                   sign_next;
  logic                    conflict_next;
  logic signed [SumW-1:0]  cross_sum;
  turn_t                   turn;

  function automatic logic signed [DiffW-1:0] sub_ext(
    input logic signed [CoordW-1:0] a,
    input logic signed [CoordW-1:0] b
  );
    return $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
  endfunction

  // pick the three triples: regular, then the two that close the ring
  always_comb begin
    ta[TriReg]   = head_job.older;
    tb[TriReg]   = head_job.newer;
    tc[TriReg]   = head_job.cur;
    ta[TriWrapA] = head_job.newer;
    tb[TriWrapA] = head_job.cur;
    tc[TriWrapA] = head_job.first;
    ta[TriWrapB] = head_job.cur;
    tb[TriWrapB] = head_job.first;
    tc[TriWrapB] = head_job.second;
  end

  // edge vectors and products of each triple
  always_comb begin
    for (int k = 0; k < NumTri; k++) begin
      dx1[k] = sub_ext(tb[k].x, ta[k].x);
      dy1[k] = sub_ext(tb[k].y, ta[k].y);
      dx2[k] = sub_ext(tc[k].x, ta[k].x);
      dy2[k] = sub_ext(tc[k].y, ta[k].y);
      prod_next.pa[k] = ProdW'(dx1[k] * dy2[k]);
      prod_next.pb[k] = ProdW'(dy1[k] * dx2[k]);
    end
    prod_next.tv[TriReg]   = (head_job.seen >= SeenW'(VertexMin - 1));
    prod_next.tv[TriWrapA] = head_job.last && (head_job.seen >= SeenW'(VertexMin - 1));
    prod_next.tv[TriWrapB] = head_job.last && (head_job.seen >= SeenW'(VertexMin - 1));
    prod_next.last         = head_job.last;
    prod_next.too_few      = head_job.last && (head_job.seen < SeenW'(VertexMin - 1));
  end

  // drain the product stage unless a verdict has nowhere to go
  assign closes = prod_valid && prod.last;
  assign drain  = prod_valid && (!prod.last || !result_valid || !result_stall);
  assign pop    = head_valid && (!prod_valid || drain);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (pop) begin
      prod_valid <= 1'b1;
    end else if (drain) begin
      prod_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prod <= prod_next;
    end
  end

  // fold the turn signs in ring order
  always_comb begin
    sign_next     = turn_sign;
    conflict_next = sign_conflict;
    cross_sum     = '0;
    turn          = TURN_ZERO;
    for (int k = 0; k < NumTri; k++) begin
      cross_sum = $signed({prod.pa[k][ProdW-1], prod.pa[k]})
                - $signed({prod.pb[k][ProdW-1], prod.pb[k]});
      if (cross_sum == '0) begin
        turn = TURN_ZERO;
      end else if (cross_sum[SumW-1]) begin
        turn = TURN_NEG;
      end else begin
        turn = TURN_POS;
      end
      if (prod.tv[k] && (turn != TURN_ZERO)) begin
        if (sign_next == TURN_ZERO) begin
          sign_next = turn;
        end else if (turn != sign_next) begin
          conflict_next = 1'b1;
        end
      end
    end
  end

  // hold turn state, clear it after each verdict
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_sign     <= TURN_ZERO;
      sign_conflict <= 1'b0;
    end else if (drain) begin
      if (prod.last) begin
        turn_sign     <= TURN_ZERO;
        sign_conflict <= 1'b0;
      end else begin
        turn_sign     <= sign_next;
        sign_conflict <= conflict_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (drain && closes) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && closes) begin
      result.is_convex <= !prod.too_few && !conflict_next;
      result.too_few   <= prod.too_few;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/convex_polygon_check.sv @@
// ----------------------------------------------------------------------------
// convex_polygon_check: polygon convexity test
// Streams vertices in, checks the cross-product sign of every consecutive
// triple around the ring and reports one verdict per polygon.
// ----------------------------------------------------------------------------
// Throughput: one vertex per cycle while the job queue is not full; a product
//   register splits the multiply and sign stages, and the two-entry job queue
//   absorbs back-end stalls. Path: the verdict passes through the job queue,
//   the product register and the result register before it shows on result.
// Reset: synchronous; clears the vertex count, queue occupancy, stage valid
//   bits and turn state. The block accepts vertices on the cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module convex_polygon_check (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  vertex_valid,
  output logic                 vertex_stall,
  input  cpc_pkg::vertex_in_t  vertex,
  output logic                 result_valid,
  input  wire                  result_stall,
  output cpc_pkg::result_t     result
);
  import cpc_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  // intake
  cpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  // decouple intake from evaluation
  cpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // evaluation and verdict
  cpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ hw/rtl/cpc_checker.sv @@
// ----------------------------------------------------------------------------
// cpc_checker: port-level checks for the convex polygon check
// Watches the top-level ports and flags verdict and reset misbehavior.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpc_checker (
  input wire                  clk,
  input wire                  rst,
  input wire                  vertex_stall,
  input wire                  result_valid,
  input wire                  result_stall,
  input cpc_pkg::result_t     result
);
  import cpc_pkg::*;

  // a stalled verdict stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // a too-few polygon is never convex
  a_too_few_not_convex: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.is_convex && result.too_few))
    else $error("too_few result marked convex");

  // reset leaves no verdict pending
  a_reset_no_result: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid after reset");

  // reset leaves the intake open
  a_reset_ready: assert property (@(posedge clk)
    $past(rst) |-> !vertex_stall)
    else $error("intake stalled after reset");

endmodule

bind convex_polygon_check cpc_checker u_cpc_checker (.*);

`default_nettype wire

@@ dv/convex_polygon_check_test.sv @@
// ----------------------------------------------------------------------------
// convex_polygon_check_test: self-checking bench for the convexity test
// Drives a short table of hand-picked polygons and then a long stream of
// random ones (round, dented, collinear, full-range and corner-heavy) with
// random input gaps and result back-pressure. Each verdict is compared with
// its typed table row or a cycle-free software copy of the ring logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module convex_polygon_check_test;
  import cpc_pkg::*;

  localparam int RandomVertices = 800;
  localparam int HoldAfter      = 400;
  localparam int HoldCycles     = 300;
  localparam int DrainLimit     = 5000;
  localparam int TailCycles     = 8;

  // one row of the directed table; typed rows carry their own verdict
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     last;
    logic                     typed;
    logic                     conv;
    logic                     few;
  } row_t;

  typedef struct packed {
    vertex_in_t v;
    logic       typed;
    result_t    verdict;
  } stim_t;

  localparam int DirRows = 24;
  localparam row_t DIR_TABLE [0:DirRows-1] = '{
    // single vertex at the coordinate extremes
    '{16'sh7fff, 16'sh8000, 1'b1, 1'b1, 1'b0, 1'b1},
    // two vertices
    '{16'sh8000, 16'sh7fff, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd0,    16'sd0,    1'b1, 1'b1, 1'b0, 1'b1},
    // collinear triangle: all turns zero
    '{16'sd0,    16'sd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd1,    16'sd1,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd2,    16'sd2,    1'b1, 1'b1, 1'b1, 1'b0},
    // counter-clockwise square
    '{16'sd0,    16'sd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd10,   16'sd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd10,   16'sd10,   1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd0,    16'sd10,   1'b1, 1'b0, 1'b0, 1'b0},
    // dented quadrilateral
    '{16'sd0,    16'sd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd10,   16'sd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd2,    16'sd2,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd0,    16'sd10,   1'b1, 1'b0, 1'b0, 1'b0},
    // full-range square: largest products
    '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sh8000, 16'sh7fff, 1'b1, 1'b0, 1'b0, 1'b0},
    // three copies of one point
    '{16'sd5,    16'sd5,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd5,    16'sd5,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd5,    16'sd5,    1'b1, 1'b1, 1'b1, 1'b0},
    // clockwise triangle
    '{16'sd0,    16'sd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd0,    16'sd10,   1'b0, 1'b0, 1'b0, 1'b0},
    '{16'sd10,   16'sd0,    1'b1, 1'b0, 1'b0, 1'b0}
  };

  logic       clk;
  logic       rst;
  logic       vertex_valid;
  logic       vertex_stall;
  vertex_in_t vertex;
  logic       result_valid;
  logic       result_stall;
  result_t    result;

  convex_polygon_check dut (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // ring state of the software copy
  point_t         first_pt;
  point_t         second_pt;
  point_t         older_pt;
  point_t         newer_pt;
  logic [SeenW-1:0] seen_cnt;
  turn_t          ring_sign;
  bit             ring_conflict;

  stim_t   stim_q[$];
  result_t verdict_q[$];

  int  mismatches;
  int  vertices_sent;
  int  polygons_done;
  int  convex_cnt;
  int  short_cnt;
  int  input_stall_cycles;
  bit  stim_done;
  bit  hold_done;

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic turn_t turn_of(point_t a, point_t b, point_t c);
    longint s;
    s = longint'($signed(a.x)) * longint'($signed(b.y))
      - longint'($signed(a.y)) * longint'($signed(b.x))
      + longint'($signed(a.y)) * longint'($signed(c.x))
      - longint'($signed(a.x)) * longint'($signed(c.y))
      + longint'($signed(b.x)) * longint'($signed(c.y))
      - longint'($signed(b.y)) * longint'($signed(c.x));
    if (s == 0) return TURN_ZERO;
    return (s < 0) ? TURN_NEG : TURN_POS;
  endfunction

  // keep the first non-zero turn, flag any later one that disagrees
  function automatic void fold_turn(turn_t t);
    if (t == TURN_ZERO) return;
    if (ring_sign == TURN_ZERO) ring_sign = t;
    else if (t != ring_sign) ring_conflict = 1'b1;
  endfunction

  function automatic void clear_ring();
    first_pt      = '0;
    second_pt     = '0;
    older_pt      = '0;
    newer_pt      = '0;
    seen_cnt      = '0;
    ring_sign     = TURN_ZERO;
    ring_conflict = 1'b0;
  endfunction

  // advance the ring by one vertex; returns 1 when a verdict is due
  function automatic bit predict_verdict(vertex_in_t v, output result_t r);
    point_t p;
    p.x = v.vertex_x;
    p.y = v.vertex_y;
    r = '0;
    if (seen_cnt == 0) first_pt = p;
    else if (seen_cnt == 1) second_pt = p;
    else fold_turn(turn_of(older_pt, newer_pt, p));
    older_pt = newer_pt;
    newer_pt = p;
    if (seen_cnt < VertexMin) seen_cnt = seen_cnt + 1'b1;
    if (!v.last_vertex) return 1'b0;
    if (seen_cnt < VertexMin) begin
      r.is_convex = 1'b0;
      r.too_few   = 1'b1;
    end else begin
      fold_turn(turn_of(older_pt, newer_pt, first_pt));
      fold_turn(turn_of(newer_pt, first_pt, second_pt));
      r.is_convex = !ring_conflict;
      r.too_few   = 1'b0;
    end
    clear_ring();
    return 1'b1;
  endfunction

  function automatic logic signed [CoordW-1:0] clip16(int val);
    if (val > 32767) return 16'sh7fff;
    if (val < -32768) return 16'sh8000;
    return 16'(val);
  endfunction

  function automatic logic signed [CoordW-1:0] corner16();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      4: return 16'sh0001;
      default: return 16'($urandom());
    endcase
  endfunction

  // append one random polygon to the stimulus
  function automatic void add_polygon();
    int    n;
    int    mode;
    int    cx;
    int    cy;
    int    rad;
    int    dent;
    int    dx;
    int    dy;
    int    k;
    real   phase;
    real   ang;
    real   dir;
    stim_t s;
    k = $urandom_range(0, 99);
    if (k < 8) n = $urandom_range(1, 2);
    else if (k < 90) n = $urandom_range(3, 8);
    else n = $urandom_range(9, 40);
    mode  = $urandom_range(0, 99);
    cx    = int'($urandom_range(0, 32000)) - 16000;
    cy    = int'($urandom_range(0, 32000)) - 16000;
    rad   = $urandom_range(1, 16000);
    dent  = $urandom_range(0, n - 1);
    dx    = int'($urandom_range(0, 400)) - 200;
    dy    = int'($urandom_range(0, 400)) - 200;
    phase = real'($urandom_range(0, 6283)) / 1000.0;
    dir   = ($urandom_range(0, 1) == 1) ? 1.0 : -1.0;
    k     = 0;
    for (int i = 0; i < n; i++) begin
      s = '0;
      if (mode < 55) begin
        // points on a circle, one of them pulled to the center if dented
        ang = phase + dir * 6.283185307 * real'(i) / real'(n);
        if (mode >= 40 && i == dent && n > 3) begin
          s.v.vertex_x = clip16(cx);
          s.v.vertex_y = clip16(cy);
        end else begin
          s.v.vertex_x = clip16(cx + $rtoi(real'(rad) * $cos(ang)));
          s.v.vertex_y = clip16(cy + $rtoi(real'(rad) * $sin(ang)));
        end
      end else if (mode < 70) begin
        // points on one line, mostly in order
        if ($urandom_range(0, 9) == 0) k = k - 1;
        else k = k + int'($urandom_range(0, 2));
        s.v.vertex_x = clip16(cx / 2 + k * dx);
        s.v.vertex_y = clip16(cy / 2 + k * dy);
      end else if (mode < 85) begin
        s.v.vertex_x = 16'($urandom());
        s.v.vertex_y = 16'($urandom());
      end else begin
        s.v.vertex_x = corner16();
        s.v.vertex_y = corner16();
      end
      s.v.last_vertex = (i == n - 1);
      stim_q = {stim_q, s};
    end
  endfunction

  // reset
  initial begin
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  // sender
  initial begin
    stim_t     s;
    result_t   r;
    int        gap;
    int        burst_left;
    int        k;
    vertex_valid  = 1'b0;
    vertex        = '0;
    stim_done     = 1'b0;
    vertices_sent = 0;
    burst_left    = 0;
    clear_ring();
    for (int i = 0; i < DirRows; i++) begin
      s.v.vertex_x    = DIR_TABLE[i].x;
      s.v.vertex_y    = DIR_TABLE[i].y;
      s.v.last_vertex = DIR_TABLE[i].last;
      s.typed             = DIR_TABLE[i].typed;
      s.verdict.is_convex = DIR_TABLE[i].conv;
      s.verdict.too_few   = DIR_TABLE[i].few;
      stim_q = {stim_q, s};
    end
    while (stim_q.size() < DirRows + RandomVertices) add_polygon();
    do @(posedge clk); while (rst);
    while (stim_q.size() > 0) begin
      s = stim_q.pop_front();
      // pick a gap: stretches with none, mostly short, a few long
      if (burst_left > 0) begin
        burst_left--;
        gap = 0;
      end else begin
        k = $urandom_range(0, 99);
        if (k < 5) begin
          burst_left = $urandom_range(30, 80);
          gap = 0;
        end else if (k < 55) gap = 0;
        else if (k < 85) gap = $urandom_range(1, 3);
        else if (k < 97) gap = $urandom_range(4, 10);
        else gap = $urandom_range(15, 60);
      end
      if (gap > 0) begin
        vertex_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      vertex_valid <= 1'b1;
      vertex       <= s.v;
      do @(posedge clk); while (vertex_stall);
      vertices_sent++;
      if (predict_verdict(s.v, r)) begin
        polygons_done++;
        if (r.too_few) short_cnt++;
        else if (r.is_convex) convex_cnt++;
        verdict_q = {verdict_q, (s.typed ? s.verdict : r)};
      end
    end
    vertex_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls plus one long hold to back the block up
  initial begin
    int stall_len;
    int free_len;
    int k;
    result_stall = 1'b0;
    hold_done    = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!hold_done && vertices_sent >= HoldAfter) begin
        hold_done = 1'b1;
        result_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 60) stall_len = 0;
        else if (k < 90) stall_len = $urandom_range(1, 3);
        else if (k < 98) stall_len = $urandom_range(4, 12);
        else stall_len = $urandom_range(20, 50);
        free_len = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 8)
                                                : $urandom_range(10, 40);
        if (stall_len > 0) begin
          result_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        result_stall <= 1'b0;
        repeat (free_len) @(posedge clk);
      end
    end
  end

  // check each accepted verdict against the oldest one waiting
  always @(posedge clk) begin
    if (!rst) begin
      if (vertex_valid && vertex_stall) input_stall_cycles++;
      if (result_valid && !result_stall) begin
        if (verdict_q.size() == 0) begin
          mismatches++;
          $display("%0t: verdict with none expected: is_convex %0b too_few %0b",
                   $time, result.is_convex, result.too_few);
        end else begin
          if (result.is_convex !== verdict_q[0].is_convex) begin
            mismatches++;
            $display("%0t: is_convex expected %0b actual %0b",
                     $time, verdict_q[0].is_convex, result.is_convex);
          end
          if (result.too_few !== verdict_q[0].too_few) begin
            mismatches++;
            $display("%0t: too_few expected %0b actual %0b",
                     $time, verdict_q[0].too_few, result.too_few);
          end
          void'(verdict_q.pop_front());
        end
      end
    end
  end

  // wait for the last verdicts, then report
  initial begin
    int waited;
    mismatches         = 0;
    polygons_done      = 0;
    convex_cnt         = 0;
    short_cnt          = 0;
    input_stall_cycles = 0;
    waited             = 0;
    wait (stim_done);
    while (verdict_q.size() > 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (TailCycles) @(posedge clk);
    if (verdict_q.size() > 0) begin
      mismatches++;
      $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
    end
    $display("covered %0d vertices in %0d polygons: %0d convex, %0d concave, %0d too short",
             vertices_sent, polygons_done, convex_cnt,
             polygons_done - convex_cnt - short_cnt, short_cnt);
    $display("input held back on %0d cycles, %0d checks failed",
             input_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("convex_polygon_check: match");
    end else begin
      $display("convex_polygon_check: mismatch");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #5_000_000;
    $display("convex_polygon_check: mismatch");
    $finish;
  end

endmodule
